// ===== hdl/sha256_pkg.sv =====
// shared types, constants and functions of the sha-256 message hasher
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;
    localparam int LEN_HIGH    = 29;

    typedef logic [7:0][31:0] hash_t;

    // controls of the round and hash unit
    typedef struct packed {
        logic       load;   // copy the chained hash into the working variables
        logic       step;   // run one compression round
        logic       fold;   // add the working variables into the chained hash
        logic       init;   // return the chained hash to its initial value
        logic [5:0] rnd;    // round number, selects the round constant
    } rnd_ctrl_t;

    // controls of the block and schedule window
    typedef struct packed {
        logic       push;   // shift one message or pad byte in
        logic       shift;  // advance the message schedule by one word
        logic [7:0] data;
    } sched_ctrl_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== hdl/sha256_message_hasher.sv =====
// top level of the sha-256 message hasher: byte intake, padding sequencer, digest output
`timescale 1ns / 1ps

// Takes one message byte per transfer (s_tuser high marks a valid byte, s_tlast ends the
// message) and returns the 256-bit digest as eight transfers, most significant word first,
// m_tlast on the eighth. The byte that fills a 64-byte block is followed by the rounds of
// the single shared round unit and a fold of the result into the chained hash, and the
// input is not ready while they run. On the end of a message the padding bytes go through
// the same byte path at one per cycle, possibly into a second block, and each padded block
// again runs the rounds and the fold before the eight digest words are sent. After the
// last digest word the hasher is back at the initial hash.
module sha256_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] data_byte
    input  logic [7:0]  s_tdata,
    // s_tuser: [0] has_byte
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FOLD  = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  pos_reg, pos_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic        first_reg, first_next;
    logic        lenok_reg, lenok_next;
    logic        finblk_reg, finblk_next;

    rnd_ctrl_t   rctrl;
    sched_ctrl_t sctrl;
    logic [31:0] w_cur;
    hash_t       hash;
    logic [63:0] len_bits;
    logic [5:0]  len_shift;
    logic [7:0]  len_byte;

    assign len_bits  = {count_reg, 3'b000};
    assign len_shift = {3'd7 - pos_reg[2:0], 3'b000};
    assign len_byte  = 8'(len_bits >> len_shift);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'b00000, idx_reg, hash[idx_reg]};
    assign m_tlast  = (idx_reg == 3'd7);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        fin_next    = fin_reg;
        first_next  = first_reg;
        lenok_next  = lenok_reg;
        finblk_next = finblk_reg;
        rctrl       = '0;
        rctrl.rnd   = round_reg[5:0];
        sctrl       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    fin_next   = s_tlast;
                    first_next = s_tlast;
                    lenok_next = 1'b0;
                    if (s_tuser) begin
                        sctrl.push = 1'b1;
                        sctrl.data = s_tdata;
                        count_next = count_reg + 61'd1;
                        pos_next   = pos_reg + 6'd1;
                    end
                    if (s_tuser && pos_reg == 6'd63) begin
                        rctrl.load = 1'b1;
                        state_next = ST_ROUND;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sctrl.push = 1'b1;
                pos_next   = pos_reg + 6'd1;
                first_next = 1'b0;
                if (first_reg) begin
                    sctrl.data = 8'h80;
                end else if (lenok_reg && pos_reg >= 6'd56) begin
                    sctrl.data = len_byte;
                end
                // the length field belongs to this block only if the pad byte came before it
                if (first_reg && pos_reg < 6'd56) begin
                    lenok_next = 1'b1;
                end
                if (pos_reg == 6'd63) begin
                    if (lenok_reg && !first_reg) begin
                        finblk_next = 1'b1;
                    end
                    lenok_next = 1'b1;
                    rctrl.load = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                rctrl.step  = 1'b1;
                sctrl.shift = 1'b1;
                round_next  = round_reg + 7'd1;
                if (round_reg == 7'd63) begin
                    round_next = 7'd0;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                rctrl.fold = 1'b1;
                if (finblk_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        rctrl.init  = 1'b1;
                        count_next  = '0;
                        pos_next    = '0;
                        fin_next    = 1'b0;
                        finblk_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            fin_reg    <= 1'b0;
            first_reg  <= 1'b0;
            lenok_reg  <= 1'b0;
            finblk_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            fin_reg    <= fin_next;
            first_reg  <= first_next;
            lenok_reg  <= lenok_next;
            finblk_reg <= finblk_next;
        end
    end

    sha256_sched u_sched (
        .aclk  (aclk),
        .ctrl  (sctrl),
        .w_out (w_cur)
    );

    sha256_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rctrl),
        .w_in    (w_cur),
        .hash    (hash)
    );

    // input and output are never open together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest is being sent");

    // round counter only moves during the rounds
    a_round_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (round_reg != 7'd0) |-> (state_reg == ST_ROUND))
        else $error("round counter left non-zero outside the rounds");

    // every fold follows the last round
    a_fold_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |-> ($past(state_reg) == ST_ROUND && $past(round_reg) == 7'd63))
        else $error("fold without a full set of rounds");

    // the final digest transfer returns the block to idle with a cleared count
    a_end_of_digest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && count_reg == 61'd0))
        else $error("not idle after the last digest word");

endmodule

// ===== hdl/sha256_sched.sv =====
// block buffer that packs bytes big-endian and then runs the message schedule
`timescale 1ns / 1ps

module sha256_sched (
    input  logic                     aclk,
    input  sha256_pkg::sched_ctrl_t  ctrl,
    output logic [31:0]              w_out
);
    import sha256_pkg::*;

    localparam int BLK_BITS = BLOCK_WORDS * 32;

    logic [BLK_BITS-1:0] blk_reg;
    logic [31:0]         w_new;

    // word i of the window sits at blk_reg[BLK_BITS-1-32*i -: 32]
    function automatic logic [31:0] word_at(input logic [BLK_BITS-1:0] b, input int i);
        return b[BLK_BITS-1-32*i -: 32];
    endfunction

    assign w_out = word_at(blk_reg, 0);
    assign w_new = small_sigma1(word_at(blk_reg, 14)) + word_at(blk_reg, 9)
                 + small_sigma0(word_at(blk_reg, 1)) + word_at(blk_reg, 0);

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            blk_reg <= {blk_reg[BLK_BITS-9:0], ctrl.data};
        end else if (ctrl.shift) begin
            blk_reg <= {blk_reg[BLK_BITS-33:0], w_new};
        end
    end

endmodule

// ===== hdl/sha256_round.sv =====
// working variables, one shared compression round and the chained hash
`timescale 1ns / 1ps

module sha256_round (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sha256_pkg::rnd_ctrl_t   ctrl,
    input  logic [31:0]             w_in,
    output sha256_pkg::hash_t       hash
);
    import sha256_pkg::*;

    hash_t       hash_reg;
    hash_t       vars_reg;
    hash_t       vars_next;
    logic [31:0] t1;
    logic [31:0] t2;

    assign hash = hash_reg;

    always_comb begin
        t1 = vars_reg[7] + big_sigma1(vars_reg[4])
           + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
           + ROUND_K[ctrl.rnd] + w_in;
        t2 = big_sigma0(vars_reg[0])
           + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
              ^ (vars_reg[1] & vars_reg[2]));
        vars_next    = vars_reg;
        vars_next[7] = vars_reg[6];
        vars_next[6] = vars_reg[5];
        vars_next[5] = vars_reg[4];
        vars_next[4] = vars_reg[3] + t1;
        vars_next[3] = vars_reg[2];
        vars_next[2] = vars_reg[1];
        vars_next[1] = vars_reg[0];
        vars_next[0] = t1 + t2;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            vars_reg <= hash_reg;
        end else if (ctrl.step) begin
            vars_reg <= vars_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= INIT_HASH;
        end else if (ctrl.init) begin
            hash_reg <= INIT_HASH;
        end else if (ctrl.fold) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_reg[i] + vars_reg[i];
            end
        end
    end

endmodule
